// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files that carry checks.
// Depends on the including module having i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define CHK_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define CHK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pli_pkg.sv -----
// Package for the positional list: sizes, command codes, cell control struct
// and word-width conversion helpers. No dependencies.
package pli_pkg;

    localparam int DEPTH  = 16;
    localparam int WORD_W = 32;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int CMD_W  = 2;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = ((POS_W > CNT_W) ? POS_W : CNT_W) + 1;
    localparam int EXT_W  = (WORD_W > DATA_W) ? WORD_W : DATA_W;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [DATA_W-1:0] t_data;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_READ   = 2'd2
    } t_cmd;

    // Per-cell control for one beat
    typedef struct packed {
        logic load;        // take the incoming word
        logic take_left;   // take the lower neighbor's word (insert shift)
        logic take_right;  // take the upper neighbor's word (delete shift)
        logic sel;         // drive this cell's word onto the read tap
    } t_cell_ctrl;

    // Port data to stored word: truncate or zero-extend
    function automatic t_word to_word(input t_data d);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(d);
        return ext[WORD_W-1:0];
    endfunction

    // Stored word to port data: truncate or zero-extend
    function automatic t_data to_data(input t_word w);
        logic [EXT_W-1:0] ext;
        ext = EXT_W'(w);
        return ext[DATA_W-1:0];
    endfunction

endpackage

// ----- rtl/pli_cell.sv -----
// One storage cell of the positional list: holds a word and shifts with its
// neighbors. Depends on pli_pkg.
module pli_cell (
    input  logic               i_clk,
    input  pli_pkg::t_cell_ctrl i_ctrl,
    input  pli_pkg::t_word     i_left,
    input  pli_pkg::t_word     i_right,
    input  pli_pkg::t_word     i_new,
    output pli_pkg::t_word     o_word,
    output pli_pkg::t_word     o_tap
);
    import pli_pkg::*;

    t_word r_word;
    t_word n_word;

    // Pick the next word: load, shift up, shift down or hold
    always_comb begin
        if (i_ctrl.load) begin
            n_word = i_new;
        end else if (i_ctrl.take_left) begin
            n_word = i_left;
        end else if (i_ctrl.take_right) begin
            n_word = i_right;
        end else begin
            n_word = r_word;
        end
    end

    // Payload only, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_tap  = i_ctrl.sel ? r_word : '0;

endmodule

// ----- rtl/positional_list_insert_delete_core.sv -----
// Positional list core: an ordered list of up to DEPTH words with insert, delete and read
// by 1-based position, held in a row of cells that all shift together in the same cycle.
// Each command gives one result beat through an output register, so a new command is
// taken every cycle as long as the result side keeps up; the rate is set by the parallel
// shift of the cell row. Bad positions, insert into a full list, read or delete on an
// empty list and unknown commands return error with data zero and leave the list as is.
// Depends on pli_pkg, pli_cell and assert_macros.svh.
`include "assert_macros.svh"

module positional_list_insert_delete_core (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [pli_pkg::CMD_W-1:0]  i_cmd,
    input  logic [pli_pkg::POS_W-1:0]  i_position,
    input  logic [pli_pkg::DATA_W-1:0] i_data_in,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [pli_pkg::DATA_W-1:0] o_data_out,
    output logic [pli_pkg::CNT_W-1:0]  o_entry_count,
    output logic                    o_error
);
    import pli_pkg::*;

    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic              r_out_valid;
    logic              n_out_valid;
    t_data             r_out_data;
    t_data             n_out_data;
    logic [CNT_W-1:0]  r_out_count;
    logic [CNT_W-1:0]  n_out_count;
    logic              r_out_err;
    logic              n_out_err;

    logic              in_fire;
    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic              ins_ok;
    logic              pick_ok;
    logic              do_ins;
    logic              do_del;
    logic              do_pick;
    t_word             new_word;
    t_word             tap_or;

    t_word      w_word [DEPTH];
    t_word      w_tap  [DEPTH];
    t_cell_ctrl w_ctrl [DEPTH];

    // Take a beat whenever the result register is free or draining
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    // Range checks against the current count
    assign pos_x    = CMP_W'(i_position);
    assign cnt_x    = CMP_W'(r_count);
    assign ins_ok   = (cnt_x < CMP_W'(DEPTH)) && (pos_x != '0) && (pos_x <= cnt_x + 1'b1);
    assign pick_ok  = (pos_x != '0) && (pos_x <= cnt_x);
    assign new_word = to_word(i_data_in);

    // Decode the command into list actions
    always_comb begin
        do_ins  = 1'b0;
        do_del  = 1'b0;
        do_pick = 1'b0;
        case (i_cmd)
            CMD_INSERT: begin
                do_ins = in_fire && ins_ok;
            end
            CMD_DELETE: begin
                do_del  = in_fire && pick_ok;
                do_pick = in_fire && pick_ok;
            end
            CMD_READ: begin
                do_pick = in_fire && pick_ok;
            end
            default: begin
                do_pick = 1'b0;
            end
        endcase
    end

    // Row of cells with per-cell shift control
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            localparam logic [CMP_W-1:0] IDX1 = CMP_W'(g + 1);
            localparam logic [CMP_W-1:0] IDX2 = CMP_W'(g + 2);
            t_word left_w;
            t_word right_w;

            always_comb begin
                w_ctrl[g].load       = do_ins && (IDX1 == pos_x);
                w_ctrl[g].take_left  = do_ins && (IDX1 > pos_x) && (IDX1 <= cnt_x + 1'b1);
                w_ctrl[g].take_right = do_del && (IDX1 >= pos_x) && (IDX2 <= cnt_x);
                w_ctrl[g].sel        = do_pick && (IDX1 == pos_x);
            end

            if (g == 0) begin : g_first
                assign left_w = new_word;
            end else begin : g_mid_l
                assign left_w = w_word[g-1];
            end

            if (g == DEPTH - 1) begin : g_last
                assign right_w = '0;
            end else begin : g_mid_r
                assign right_w = w_word[g+1];
            end

            pli_cell u_cell (
                .i_clk   (i_clk),
                .i_ctrl  (w_ctrl[g]),
                .i_left  (left_w),
                .i_right (right_w),
                .i_new   (new_word),
                .o_word  (w_word[g]),
                .o_tap   (w_tap[g])
            );
        end
    endgenerate

    // Gather the selected cell; at most one tap is nonzero
    always_comb begin
        tap_or = '0;
        for (int k = 0; k < DEPTH; k++) begin
            tap_or = tap_or | w_tap[k];
        end
    end

    // Advance the count
    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + 1'b1;
        end else if (do_del) begin
            n_count = r_count - 1'b1;
        end
    end

    // Load the result register on a beat, drop it when taken
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_count = r_out_count;
        n_out_err   = r_out_err;
        if (in_fire) begin
            n_out_valid = 1'b1;
            n_out_data  = to_data(tap_or);
            n_out_count = n_count;
            n_out_err   = !(do_ins || do_pick);
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_out_count <= n_out_count;
        r_out_err   <= n_out_err;
    end

    assign o_out_valid   = r_out_valid;
    assign o_data_out    = r_out_data;
    assign o_entry_count = r_out_count;
    assign o_error       = r_out_err;

    `CHK_IMPL(a_count_max, 1'b1, r_count <= CNT_W'(DEPTH), "entry count above depth")
    `CHK_NEXT(a_ins_count, do_ins, r_count == $past(r_count) + 1'b1, "insert did not grow list")
    `CHK_NEXT(a_fire_result, in_fire, r_out_valid && r_out_count == r_count, "result lost")
    `CHK_IMPL(a_err_zero, r_out_valid && r_out_err, r_out_data == '0, "error with data")

endmodule

// ----- tb/sv/pli_list_checker.sv -----
// Checker for the positional list core: watches the command and result channels,
// keeps its own copy of the list and compares every result beat against it.
// Depends on pli_pkg for sizes and command codes.
`timescale 1ns / 1ps

module pli_list_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [pli_pkg::CMD_W-1:0]  i_cmd,
    input  logic [pli_pkg::POS_W-1:0]  i_position,
    input  logic [pli_pkg::DATA_W-1:0] i_data_in,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [pli_pkg::DATA_W-1:0] i_data_out,
    input  logic [pli_pkg::CNT_W-1:0]  i_entry_count,
    input  logic                       i_error,
    output int                         o_fail_count,
    output int                         o_pending
);
    import pli_pkg::*;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [CNT_W-1:0]  count;
        logic              err;
    } list_result_t;

    logic [WORD_W-1:0] list_cells [DEPTH];
    int                list_len;
    int                mismatches;
    list_result_t      expected_results [$];

    initial begin
        list_len     = 0;
        mismatches   = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Apply one command to the shadow list and return the result it must produce
    function automatic list_result_t apply_command(input logic [CMD_W-1:0] c,
                                                   input logic [POS_W-1:0] p,
                                                   input logic [DATA_W-1:0] d);
        list_result_t r;
        int           idx;
        int           k;
        r   = '0;
        idx = int'(p);
        case (c)
            CMD_INSERT: begin
                if (list_len >= DEPTH || idx < 1 || idx > list_len + 1) begin
                    r.err = 1'b1;
                end else begin
                    // open a gap at idx-1 by shifting the tail up
                    for (k = list_len; k > idx - 1; k--)
                        list_cells[k] = list_cells[k-1];
                    list_cells[idx-1] = WORD_W'(d);
                    list_len++;
                end
            end
            CMD_DELETE: begin
                if (list_len == 0 || idx < 1 || idx > list_len) begin
                    r.err = 1'b1;
                end else begin
                    r.data = DATA_W'(list_cells[idx-1]);
                    // close the gap by shifting the tail down
                    for (k = idx - 1; k + 1 < list_len; k++)
                        list_cells[k] = list_cells[k+1];
                    list_len--;
                end
            end
            CMD_READ: begin
                if (list_len == 0 || idx < 1 || idx > list_len)
                    r.err = 1'b1;
                else
                    r.data = DATA_W'(list_cells[idx-1]);
            end
            default: begin
                r.err = 1'b1;
            end
        endcase
        r.count = CNT_W'(list_len);
        return r;
    endfunction

    // Retire result beats first, then queue the prediction for a new command beat
    always @(posedge i_clk) begin
        list_result_t want;
        if (!i_rst_n) begin
            expected_results.delete();
            list_len = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no command waiting: data_out %h count %0d err %0b",
                           i_data_out, i_entry_count, i_error);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_data_out !== want.data) begin
                        $error("data_out: expected %h, got %h", want.data, i_data_out);
                        mismatches++;
                    end
                    if (i_entry_count !== want.count) begin
                        $error("entry_count: expected %0d, got %0d", want.count, i_entry_count);
                        mismatches++;
                    end
                    if (i_error !== want.err) begin
                        $error("error: expected %0b, got %0b", want.err, i_error);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(apply_command(i_cmd, i_position, i_data_in));
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

// ----- tb/sv/tb_positional_list_insert_delete_core.sv -----
// Top of the positional list regression: clock, reset, command stimulus, result-side
// back-pressure and the verdict. Depends on pli_pkg, the core and pli_list_checker.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_core;
    import pli_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int STALL_MAX    = 17;
    localparam int HOLD_AT      = 150;
    localparam int HOLD_CYCLES  = 120;
    localparam int IDLE_LIMIT   = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              in_valid;
    logic              in_ready;
    logic [CMD_W-1:0]  cmd;
    logic [POS_W-1:0]  position;
    logic [DATA_W-1:0] data_in;
    logic              out_valid;
    logic              out_ready;
    logic [DATA_W-1:0] data_out;
    logic [CNT_W-1:0]  entry_count;
    logic              error_flag;
    int                fail_count;
    int                pending;
    int                idle_cycles;
    int                list_len;
    bit                tx_burst;

    positional_list_insert_delete_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (in_ready),
        .i_cmd         (cmd),
        .i_position    (position),
        .i_data_in     (data_in),
        .o_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .o_data_out    (data_out),
        .o_entry_count (entry_count),
        .o_error       (error_flag)
    );

    pli_list_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_cmd         (cmd),
        .i_position    (position),
        .i_data_in     (data_in),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_data_out    (data_out),
        .i_entry_count (entry_count),
        .i_error       (error_flag),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Watchdog: end the run when no beat moves on either channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("positional_list_insert_delete_core regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Result side: random stalls, bursts of steady ready, one long hold-off
    initial begin
        int  stall;
        int  rx_beats;
        bit  rx_burst;
        out_ready = 1'b0;
        rx_beats  = 0;
        rx_burst  = 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (rx_beats == HOLD_AT) begin
                // hold off long enough that the core fills and stalls its input
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if ($urandom_range(0, 15) == 0)
                    rx_burst = ~rx_burst;
                stall = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
                if (stall > 0) begin
                    out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
            end
            out_ready <= 1'b1;
            do @(posedge i_clk); while (!out_valid);
            rx_beats++;
        end
    end

    // Offer one command beat after a random gap and hold it until accepted
    task automatic send_beat(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                             input logic [DATA_W-1:0] d);
        int gap;
        int idx;
        if ($urandom_range(0, 15) == 0)
            tx_burst = ~tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, STALL_MAX);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        position <= p;
        data_in  <= d;
        do @(posedge i_clk); while (!in_ready);
        // track the fill level so the random part can aim at legal positions
        idx = int'(p);
        if (c == CMD_INSERT && list_len < DEPTH && idx >= 1 && idx <= list_len + 1)
            list_len++;
        else if (c == CMD_DELETE && idx >= 1 && idx <= list_len)
            list_len--;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results;
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    initial begin
        int                n;
        int                roll;
        bit                grow;
        logic [CMD_W-1:0]  c;
        logic [POS_W-1:0]  p;
        i_rst_n  = 1'b0;
        in_valid = 1'b0;
        cmd      = CMD_INSERT;
        position = '0;
        data_in  = '0;
        list_len = 0;
        tx_burst = 1'b0;
        grow     = 1'b1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty list, bad positions, fill to full, edges, unused code
        send_beat(CMD_READ, 5'd1, '0);
        send_beat(CMD_DELETE, 5'd1, '0);
        send_beat(CMD_INSERT, 5'd0, 32'h1111_1111);
        send_beat(CMD_INSERT, 5'd2, 32'h2222_2222);
        send_beat(CMD_INSERT, 5'd1, '0);
        send_beat(CMD_INSERT, 5'd2, '1);
        for (n = 2; n < DEPTH; n++) begin
            case (n % 3)
                0:       p = 5'd1;
                1:       p = POS_W'(list_len / 2 + 1);
                default: p = POS_W'(list_len + 1);
            endcase
            send_beat(CMD_INSERT, p, $urandom);
        end
        send_beat(CMD_INSERT, POS_W'(DEPTH + 1), 32'hDEAD_BEEF);
        send_beat(CMD_INSERT, '1, 32'hDEAD_BEEF);
        send_beat(CMD_READ, 5'd0, '0);
        send_beat(CMD_READ, POS_W'(DEPTH + 1), '0);
        send_beat(CMD_READ, POS_W'(DEPTH), '0);
        send_beat(CMD_UNUSED, 5'd1, '1);
        send_beat(CMD_DELETE, POS_W'(DEPTH), '0);
        send_beat(CMD_DELETE, 5'd1, '0);
        send_beat(CMD_DELETE, 5'd5, '0);
        drain_results();

        // Random: mostly legal commands steered between empty and full, some noise
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 40 == 0)
                grow = 1'($urandom_range(0, 1));
            if (n == RANDOM_ITEMS / 2)
                drain_results();
            roll = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0) begin
                c = CMD_W'($urandom_range(0, 3));
                p = POS_W'($urandom_range(0, 31));
            end else begin
                if (list_len == 0)
                    c = CMD_INSERT;
                else if (list_len == DEPTH)
                    c = (roll < 60) ? CMD_DELETE : CMD_READ;
                else if (grow)
                    c = (roll < 55) ? CMD_INSERT : (roll < 80) ? CMD_DELETE : CMD_READ;
                else
                    c = (roll < 20) ? CMD_INSERT : (roll < 65) ? CMD_DELETE : CMD_READ;
                if (c == CMD_INSERT)
                    p = POS_W'($urandom_range(1, list_len + 1));
                else
                    p = POS_W'($urandom_range(1, list_len));
            end
            send_beat(c, p, $urandom);
        end

        // Wait out the last results and the output register
        drain_results();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("positional_list_insert_delete_core regression: pass");
        else
            $display("positional_list_insert_delete_core regression: fail");
        $finish;
    end

endmodule
